### hw/rtl/ebld_pkg.sv
// Shared types and constants of the escape-byte LZ decompressor.
// Used by the top level, the history RAM and the checker; depends on nothing.
`default_nettype none

package ebld_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int ADDR_W = $clog2(WINDOW_DEPTH);
   localparam int LIMIT_W = 25;
   localparam int OUT_W = 32;
   localparam int BCNT_W = 3;
   localparam int BYTES_PER_RESULT_DEF = 4;

   localparam logic [7:0] ESCAPE_BYTE = 8'hAD;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd262144;

   // token phase codes
   localparam logic [1:0] PH_PLAIN = 2'd0;
   localparam logic [1:0] PH_DIST = 2'd1;
   localparam logic [1:0] PH_LEN = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN = 3'b010,
      ST_FAULT = 3'b100
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0] wr_data;
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

### hw/rtl/ebld_history_ram.sv
// History window RAM: one write and one read port, registered read data.
// A read of the address written in the same cycle returns the new byte.
// Depends on ebld_pkg.
`default_nettype none

module ebld_history_ram (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ebld_pkg::ram_req_type ram_req,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [ebld_pkg::WINDOW_DEPTH];
   logic [7:0] rd_data_ff;
   logic [7:0] fwd_data_ff;
   logic       fwd_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
         fwd_data_ff <= ram_req.wr_data;
      end
   end

   // held along with the read data while no read is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (ram_req.rd_en) begin
         fwd_ff <= ram_req.wr_en && (ram_req.wr_addr == ram_req.rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/escape_byte_lz_decompressor_unit.sv
// Top level of the escape-byte LZ decompressor: token decode, copy sequencer,
// result packer and output register. Depends on ebld_pkg and ebld_history_ram.
//
//   channel | direction | ports               | beat
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_ready | one compressed byte + stream flags
//   rsp     | out       | rsp_valid/rsp_ready | up to BYTES_PER_RESULT decoded bytes
//   csr     | in        | csr_wr_en           | output_limit write, no wait
//
// A token byte that emits nothing is only accepted; a literal or a copy is
// accepted, then written one byte per cycle through the single write port of
// the history RAM; a bad distance is accepted, then reported from ST_FAULT.
// Reset clears all control state; the history RAM has no clearing pass. A
// result beat that cannot leave because rsp_ready is low stalls the run on the
// byte that completes it; the other bytes keep going.
`default_nettype none

module escape_byte_lz_decompressor_unit #(
   parameter int BYTES_PER_RESULT = ebld_pkg::BYTES_PER_RESULT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_in_byte,
   input  wire logic                        req_stream_start,
   input  wire logic                        req_stream_end,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [ebld_pkg::OUT_W-1:0]       rsp_out_bytes,
   output logic [ebld_pkg::BCNT_W-1:0]      rsp_byte_count,
   output logic                             rsp_run_last,
   output logic                             rsp_bad_distance,
   output logic                             rsp_limit_reached,
   output logic [ebld_pkg::LIMIT_W-1:0]     rsp_total_produced,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [ebld_pkg::LIMIT_W-1:0] csr_wr_data
);

   localparam int PACK_W = 8 * BYTES_PER_RESULT;
   localparam int CNT_W = $clog2(BYTES_PER_RESULT + 1);
   localparam int AW = ebld_pkg::ADDR_W;
   localparam int LW = ebld_pkg::LIMIT_W;

   // ---------------------------------------------------------------------
   // Stream state
   // ---------------------------------------------------------------------
   ebld_pkg::state_type state_ff;
   logic [AW-1:0]       wp_ff;        // history write pointer, kept across streams
   logic [LW-1:0]       prod_ff;      // bytes produced in this stream
   logic [1:0]          phase_ff;
   logic [7:0]          dist_ff;
   logic                stop_ff;
   logic [LW-1:0]       limit_ff;

   // run (literal or copy) state
   logic                src_lit_ff;   // byte comes from lit_ff, not the RAM
   logic [7:0]          lit_ff;
   logic [7:0]          rem_ff;       // bytes still to emit in this run
   logic [AW-1:0]       rd_addr_ff;   // next copy source address
   logic [PACK_W-1:0]   pack_ff;
   logic [CNT_W-1:0]    pcnt_ff;      // bytes already held in pack_ff

   // output register
   logic                     rsp_valid_ff;
   logic [ebld_pkg::OUT_W-1:0]  out_bytes_ff;
   logic [ebld_pkg::BCNT_W-1:0] byte_count_ff;
   logic                     run_last_ff;
   logic                     bad_dist_ff;
   logic                     limit_hit_ff;
   logic [LW-1:0]            total_ff;

   // ---------------------------------------------------------------------
   // Token decode of the beat on the request channel
   // ---------------------------------------------------------------------
   logic          accept;
   logic [LW-1:0] prod_eff;
   logic [1:0]    phase_eff;
   logic [7:0]    dist_eff;
   logic          stop_eff;
   logic [LW-1:0] room;
   logic [7:0]    copy_len;
   logic          dec_lit;
   logic [7:0]    dec_lit_val;
   logic          dec_copy;
   logic          dec_err;
   logic [1:0]    phase_dec;
   logic [7:0]    dist_dec;

   assign req_ready = (state_ff == ebld_pkg::ST_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      // stream start wipes count, phase, distance and stop before the byte is decoded
      prod_eff = req_stream_start ? '0 : prod_ff;
      phase_eff = req_stream_start ? ebld_pkg::PH_PLAIN : phase_ff;
      dist_eff = req_stream_start ? 8'd0 : dist_ff;
      stop_eff = (!req_stream_start && stop_ff) || (prod_eff >= limit_ff);
      // while not stopped, room is nonzero and does not exceed the limit
      room = limit_ff - prod_eff;
      copy_len = ({{(LW-8){1'b0}}, req_in_byte} < room) ? req_in_byte : room[7:0];

      dec_lit = 1'b0;
      dec_lit_val = req_in_byte;
      dec_copy = 1'b0;
      dec_err = 1'b0;
      phase_dec = phase_eff;
      dist_dec = dist_eff;

      if (!stop_eff) begin
         unique case (phase_eff)
            ebld_pkg::PH_PLAIN: begin
               if (req_in_byte == ebld_pkg::ESCAPE_BYTE) begin
                  phase_dec = ebld_pkg::PH_DIST;
               end else begin
                  dec_lit = 1'b1;
               end
            end
            ebld_pkg::PH_DIST: begin
               if (req_in_byte == 8'd0) begin
                  // escaped escape: literal 0xad
                  dec_lit = 1'b1;
                  dec_lit_val = ebld_pkg::ESCAPE_BYTE;
                  phase_dec = ebld_pkg::PH_PLAIN;
               end else begin
                  dist_dec = req_in_byte;
                  phase_dec = ebld_pkg::PH_LEN;
               end
            end
            default: begin
               // length byte closes the token
               phase_dec = ebld_pkg::PH_PLAIN;
               if ({{(LW-8){1'b0}}, dist_eff} > prod_eff) begin
                  dec_err = 1'b1;
               end else if (copy_len != 8'd0) begin
                  dec_copy = 1'b1;
               end
            end
         endcase
      end

      // incomplete token at stream end is dropped
      if (req_stream_end && (phase_dec != ebld_pkg::PH_PLAIN)) begin
         phase_dec = ebld_pkg::PH_PLAIN;
      end
   end

   // ---------------------------------------------------------------------
   // Byte path: one byte per cycle, unless a beat-closing byte waits, into history and packer
   // ---------------------------------------------------------------------
   ebld_pkg::ram_req_type ram_req;
   logic [7:0]        ram_rd_data;
   logic [7:0]        byte_val;
   logic              out_free;
   logic              run_last;
   logic              pack_full;
   logic              completes;
   logic              byte_go;
   logic [LW-1:0]     prod_next;
   logic [PACK_W-1:0] pack_base;
   logic [PACK_W-1:0] pack_next;
   logic [CNT_W-1:0]  pcnt_next;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign byte_val = src_lit_ff ? lit_ff : ram_rd_data;
   assign run_last = (rem_ff == 8'd1);
   assign pack_full = (pcnt_ff == CNT_W'(BYTES_PER_RESULT - 1));
   assign completes = run_last || pack_full;
   // only the byte that closes a beat waits for the output register
   assign byte_go = (state_ff == ebld_pkg::ST_RUN) && (!completes || out_free);
   assign prod_next = prod_ff + LW'(1);
   assign pack_base = (pcnt_ff == '0) ? '0 : pack_ff;
   assign pack_next = pack_base | (PACK_W'(byte_val) << {pcnt_ff, 3'b000});
   assign pcnt_next = pcnt_ff + CNT_W'(1);

   always_comb begin
      ram_req.wr_en = byte_go;
      ram_req.wr_addr = wp_ff;
      ram_req.wr_data = byte_val;
      // first copy read goes out with the accept; each written copy byte issues
      // the read of the next source byte (distance one hits the forward path)
      ram_req.rd_en = (accept && dec_copy) || (byte_go && !src_lit_ff && !run_last);
      ram_req.rd_addr = accept ? (wp_ff - dist_eff) : rd_addr_ff;
   end

   ebld_history_ram u_history (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // Control sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebld_pkg::ST_IDLE;
         wp_ff <= '0;
         prod_ff <= '0;
         phase_ff <= ebld_pkg::PH_PLAIN;
         dist_ff <= '0;
         stop_ff <= 1'b0;
         limit_ff <= ebld_pkg::LIMIT_RESET;
         pcnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ebld_pkg::ST_IDLE: begin
               if (accept) begin
                  prod_ff <= prod_eff;
                  phase_ff <= phase_dec;
                  dist_ff <= dist_dec;
                  stop_ff <= stop_eff;
                  pcnt_ff <= '0;
                  if (dec_lit || dec_copy) begin
                     state_ff <= ebld_pkg::ST_RUN;
                  end else if (dec_err) begin
                     state_ff <= ebld_pkg::ST_FAULT;
                  end
               end
            end
            ebld_pkg::ST_RUN: begin
               if (byte_go) begin
                  wp_ff <= wp_ff + AW'(1);
                  prod_ff <= prod_next;
                  if (prod_next >= limit_ff) begin
                     stop_ff <= 1'b1;
                  end
                  pcnt_ff <= completes ? '0 : pcnt_next;
                  if (run_last) begin
                     state_ff <= ebld_pkg::ST_IDLE;
                  end
               end
            end
            ebld_pkg::ST_FAULT: begin
               if (out_free) begin
                  state_ff <= ebld_pkg::ST_IDLE;
               end
            end
            default: begin
               state_ff <= ebld_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      if (accept) begin
         src_lit_ff <= dec_lit;
         lit_ff <= dec_lit_val;
         rem_ff <= dec_lit ? 8'd1 : copy_len;
         rd_addr_ff <= wp_ff - dist_eff + AW'(1);
      end else if (byte_go) begin
         rem_ff <= rem_ff - 8'd1;
         pack_ff <= pack_next;
         if (ram_req.rd_en) begin
            rd_addr_ff <= rd_addr_ff + AW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic load_data;
   logic load_err;

   assign load_data = byte_go && completes;
   assign load_err = (state_ff == ebld_pkg::ST_FAULT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_data || load_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_data) begin
         out_bytes_ff <= pack_next[ebld_pkg::OUT_W-1:0];
         byte_count_ff <= ebld_pkg::BCNT_W'(pcnt_next);
         run_last_ff <= run_last;
         bad_dist_ff <= 1'b0;
         limit_hit_ff <= (prod_next >= limit_ff);
         total_ff <= prod_next;
      end else if (load_err) begin
         out_bytes_ff <= '0;
         byte_count_ff <= '0;
         run_last_ff <= 1'b1;
         bad_dist_ff <= 1'b1;
         limit_hit_ff <= (prod_ff >= limit_ff);
         total_ff <= prod_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_bytes = out_bytes_ff;
   assign rsp_byte_count = byte_count_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_bad_distance = bad_dist_ff;
   assign rsp_limit_reached = limit_hit_ff;
   assign rsp_total_produced = total_ff;

endmodule

`default_nettype wire

### hw/rtl/ebld_checker.sv
// Port-level checks of the escape-byte LZ decompressor, bound to its top level.
// Depends on ebld_pkg and escape_byte_lz_decompressor_unit.
`default_nettype none

module ebld_checker #(
   parameter int BPR = ebld_pkg::BYTES_PER_RESULT_DEF
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [ebld_pkg::OUT_W-1:0]   rsp_out_bytes,
   input wire logic [ebld_pkg::BCNT_W-1:0]  rsp_byte_count,
   input wire logic                         rsp_run_last,
   input wire logic                         rsp_bad_distance,
   input wire logic [ebld_pkg::LIMIT_W-1:0] rsp_total_produced
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes)
         && $stable(rsp_total_produced))
      else $error("rsp beat changed while stalled");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_distance |-> rsp_byte_count == '0 && rsp_run_last
         && rsp_out_bytes == '0)
      else $error("malformed error beat");

   // only the last beat of a run may be partial
   a_full_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_byte_count == ebld_pkg::BCNT_W'(BPR))
      else $error("non-last beat not full");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind escape_byte_lz_decompressor_unit ebld_checker #(.BPR(BYTES_PER_RESULT)) u_ebld_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_bytes      (rsp_out_bytes),
   .rsp_byte_count     (rsp_byte_count),
   .rsp_run_last       (rsp_run_last),
   .rsp_bad_distance   (rsp_bad_distance),
   .rsp_total_produced (rsp_total_produced)
);

`default_nettype wire
